@@ hdl/rlegd_pkg.sv @@
`default_nettype none

package rlegd_pkg;

  localparam int MAX_ROW_WIDTH_DEF     = 256;
  localparam int PIXELS_PER_RESULT_DEF = 8;
  localparam int ROW_WIDTH_W           = 9;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 9'd16;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_END_ROW = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  localparam logic [7:0] RUN_FLAG_MASK = 8'h80;
  localparam logic [7:0] LEVEL_MASK    = 8'h7f;
  localparam logic [7:0] LEVEL_NEAR_MAX = 8'd254;
  localparam logic [7:0] LEVEL_MAX     = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] code_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_0;
    logic [7:0] pixel_1;
    logic [7:0] pixel_2;
    logic [7:0] pixel_3;
    logic [7:0] pixel_4;
    logic [7:0] pixel_5;
    logic [7:0] pixel_6;
    logic [7:0] pixel_7;
    logic [3:0] pixel_count;
    logic       row_done;
    logic [1:0] row_status;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic start;  // input transfer: latch the fill job, update row state
    logic load;   // move the next pixel group into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_emit;   // the presented item produces at least one result
    logic slot_free;   // output register empty or draining this cycle
    logic last_group;  // the pending group is the last of the job
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/rlegd_ctrl.sv @@
`default_nettype none

module rlegd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rlegd_pkg::stat_t stat,
  output rlegd_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid && stat.need_emit) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.load = stat.slot_free;
        if (stat.slot_free && stat.last_group) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rlegd_datapath.sv @@
`default_nettype none

module rlegd_datapath #(
  parameter int MAX_ROW_WIDTH     = rlegd_pkg::MAX_ROW_WIDTH_DEF,
  parameter int PIXELS_PER_RESULT = rlegd_pkg::PIXELS_PER_RESULT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [rlegd_pkg::ROW_WIDTH_W-1:0]   cfg_wdata,
  input  wire rlegd_pkg::in_t                      in_data,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output rlegd_pkg::out_t                          out_data,
  input  wire rlegd_pkg::cmd_t                     cmd,
  output rlegd_pkg::stat_t                         stat
);

  localparam int POS_W   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int EW_W    = (POS_W > rlegd_pkg::ROW_WIDTH_W) ? POS_W : rlegd_pkg::ROW_WIDTH_W;
  localparam int MAX_CNT = (MAX_ROW_WIDTH > 128) ? MAX_ROW_WIDTH : 128;
  localparam int CNT_W   = $clog2(MAX_CNT + 1);

  // row state
  logic [rlegd_pkg::ROW_WIDTH_W-1:0] row_width;
  logic                              awaiting_value;
  logic [7:0]                        run_length;
  logic [POS_W-1:0]                  row_position;
  logic                              overflow_seen;

  // fill job
  logic [7:0]       fill_value;
  logic [CNT_W-1:0] fill_cnt;
  logic             fill_final;
  logic [1:0]       fill_status;

  logic [EW_W-1:0]  rw_ext;
  logic [POS_W-1:0] eff_width;
  logic [POS_W-1:0] room;
  logic [CNT_W-1:0] room_c;
  logic [CNT_W-1:0] want;
  logic [CNT_W-1:0] take;
  logic             over;
  logic [7:0]       lit_value;
  logic [7:0]       job_value;
  logic [CNT_W-1:0] job_cnt;
  logic [1:0]       end_status;
  logic             is_end;
  logic             is_header;

  logic [3:0]       grp_take;
  logic [CNT_W-1:0] cnt_left;
  logic [7:0]       grp_px [8];

  always_comb begin
    rw_ext    = EW_W'(row_width);
    eff_width = (rw_ext > EW_W'(MAX_ROW_WIDTH)) ? POS_W'(MAX_ROW_WIDTH) : POS_W'(rw_ext);
    room      = (row_position < eff_width) ? (eff_width - row_position) : '0;
    room_c    = CNT_W'(room);

    is_end    = (in_data.action == rlegd_pkg::ACT_END_ROW);
    is_header = !awaiting_value && ((in_data.code_byte & rlegd_pkg::RUN_FLAG_MASK) != 8'd0);

    lit_value = {in_data.code_byte[6:0], 1'b0};
    if (lit_value == rlegd_pkg::LEVEL_NEAR_MAX) begin
      lit_value = rlegd_pkg::LEVEL_MAX;
    end

    // pixels wanted by a byte: the pending run, or one literal
    want = awaiting_value ? CNT_W'(run_length) : CNT_W'(1);
    over = (want > room_c);
    take = over ? room_c : want;

    end_status = awaiting_value ? rlegd_pkg::STATUS_TRUNCATED
               : (overflow_seen ? rlegd_pkg::STATUS_OVERFLOW : rlegd_pkg::STATUS_OK);

    job_value = is_end ? 8'd0 : (awaiting_value ? in_data.code_byte : lit_value);
    job_cnt   = is_end ? room_c : take;

    stat.need_emit = is_end || (!is_header && (take != '0));

    grp_take = (fill_cnt > CNT_W'(PIXELS_PER_RESULT)) ? 4'(PIXELS_PER_RESULT)
                                                      : 4'(fill_cnt);
    cnt_left = fill_cnt - CNT_W'(grp_take);
    stat.last_group = (cnt_left == '0);
    stat.slot_free  = !out_valid || out_ready;

    for (int j = 0; j < 8; j++) begin
      grp_px[j] = (4'(j) < grp_take) ? fill_value : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= rlegd_pkg::ROW_WIDTH_RST;
      awaiting_value <= 1'b0;
      run_length     <= '0;
      row_position   <= '0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end

      if (cmd.start) begin
        if (is_end) begin
          awaiting_value <= 1'b0;
          run_length     <= '0;
          row_position   <= '0;
          overflow_seen  <= 1'b0;
        end else if (is_header) begin
          awaiting_value <= 1'b1;
          run_length     <= (in_data.code_byte & rlegd_pkg::LEVEL_MASK) + 8'd1;
        end else begin
          awaiting_value <= 1'b0;
          run_length     <= '0;
          row_position   <= row_position + POS_W'(take);
          if (over) begin
            overflow_seen <= 1'b1;
          end
        end
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      fill_value  <= job_value;
      fill_cnt    <= job_cnt;
      fill_final  <= is_end;
      fill_status <= end_status;
    end else if (cmd.load) begin
      fill_cnt <= cnt_left;
    end

    if (cmd.load) begin
      out_data.pixel_0     <= grp_px[0];
      out_data.pixel_1     <= grp_px[1];
      out_data.pixel_2     <= grp_px[2];
      out_data.pixel_3     <= grp_px[3];
      out_data.pixel_4     <= grp_px[4];
      out_data.pixel_5     <= grp_px[5];
      out_data.pixel_6     <= grp_px[6];
      out_data.pixel_7     <= grp_px[7];
      out_data.pixel_count <= grp_take;
      out_data.row_done    <= fill_final && stat.last_group;
      out_data.row_status  <= (fill_final && stat.last_group) ? fill_status
                                                              : rlegd_pkg::STATUS_OK;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rle_glyph_row_decoder_core.sv @@
`default_nettype none

// Channel  Dir  Handshake             Payload
// cfg      in   cfg_we (no wait)      cfg_wdata: row_width, 9 bits
// in       in   in_valid / in_ready   in_data:  rlegd_pkg::in_t
// out      out  out_valid / out_ready out_data: rlegd_pkg::out_t
//
// An item is taken when in_valid meets in_ready, then its results leave one group of
// up to PIXELS_PER_RESULT pixels per cycle while out is not stalled (an end of row
// always makes at least one group, even with no padding); an item with no result
// makes no group and leaves in_ready high.
// rst is synchronous; row_width returns to 16 and the row state clears.
// A stall on out holds the output register and the group loop; in_ready
// is high only between items.
module rle_glyph_row_decoder_core #(
  parameter int MAX_ROW_WIDTH     = rlegd_pkg::MAX_ROW_WIDTH_DEF,
  parameter int PIXELS_PER_RESULT = rlegd_pkg::PIXELS_PER_RESULT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rlegd_pkg::ROW_WIDTH_W-1:0] cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire rlegd_pkg::in_t                    in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output rlegd_pkg::out_t                        out_data
);

  rlegd_pkg::cmd_t  cmd;
  rlegd_pkg::stat_t stat;

  rlegd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlegd_datapath #(
    .MAX_ROW_WIDTH     (MAX_ROW_WIDTH),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ tb/sv/rle_glyph_row_decoder_core_tb.sv @@
`default_nettype none

module rle_glyph_row_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OW       = $bits(rlegd_pkg::out_t);
  localparam int PIX_PER  = rlegd_pkg::PIXELS_PER_RESULT_DEF;
  localparam int MAX_W    = rlegd_pkg::MAX_ROW_WIDTH_DEF;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we = 1'b0;
  logic [rlegd_pkg::ROW_WIDTH_W-1:0] cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  rlegd_pkg::in_t                    in_data = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  rlegd_pkg::out_t                   out_data;

  rle_glyph_row_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // stimulus and expectations
  rlegd_pkg::in_t  code_items_q[$];
  rlegd_pkg::out_t pixel_groups_exp[$];

  int unsigned issue_cnt = 0;
  int unsigned accept_cnt = 0;
  int unsigned groups_seen = 0;
  int unsigned rows_closed = 0;
  int unsigned items_queued = 0;
  int unsigned errors = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  bit          calm = 1'b0;

  // decoder state as predicted
  int unsigned width_cfg;
  bit          awaiting_val;
  int unsigned pend_run;
  int unsigned row_pos;
  bit          ovf_seen;

  function automatic void clear_row();
    awaiting_val = 1'b0;
    pend_run     = 0;
    row_pos      = 0;
    ovf_seen     = 1'b0;
  endfunction

  function automatic int unsigned room_left();
    int unsigned w;
    w = (width_cfg > MAX_W) ? MAX_W : width_cfg;
    return (row_pos < w) ? w - row_pos : 0;
  endfunction

  // split count copies of value into groups; the last one closes the row if asked
  function automatic void push_fill(logic [7:0] value, int unsigned count, bit closes_row,
                                    logic [1:0] status);
    int unsigned left;
    int unsigned take;
    logic [OW-1:0] v;
    rlegd_pkg::out_t g;
    left = count;
    if (left == 0 && !closes_row) return;
    do begin
      take = (left > PIX_PER) ? PIX_PER : left;
      v = '0;
      for (int j = 0; j < PIX_PER; j++)
        if (j < take) v[OW-1-8*j -: 8] = value;
      g = rlegd_pkg::out_t'(v);
      left -= take;
      g.pixel_count = take[3:0];
      g.row_done    = closes_row && left == 0;
      g.row_status  = (closes_row && left == 0) ? status : rlegd_pkg::STATUS_OK;
      pixel_groups_exp.push_back(g);
    end while (left > 0);
  endfunction

  function automatic void place_pixels(logic [7:0] value, int unsigned count);
    int unsigned take;
    take = count;
    if (take > room_left()) begin
      take     = room_left();
      ovf_seen = 1'b1;
    end
    row_pos += take;
    push_fill(value, take, 1'b0, rlegd_pkg::STATUS_OK);
  endfunction

  function automatic void decode_item(rlegd_pkg::in_t it);
    logic [7:0] lvl;
    logic [1:0] st;
    if (it.action == rlegd_pkg::ACT_END_ROW) begin
      st = awaiting_val ? rlegd_pkg::STATUS_TRUNCATED
         : (ovf_seen ? rlegd_pkg::STATUS_OVERFLOW : rlegd_pkg::STATUS_OK);
      push_fill(8'h00, room_left(), 1'b1, st);
      clear_row();
      rows_closed++;
    end else if (awaiting_val) begin
      awaiting_val = 1'b0;
      place_pixels(it.code_byte, pend_run);
      pend_run = 0;
    end else if ((it.code_byte & rlegd_pkg::RUN_FLAG_MASK) != 0) begin
      awaiting_val = 1'b1;
      pend_run     = int'(it.code_byte & rlegd_pkg::LEVEL_MASK) + 1;
    end else begin
      lvl = {it.code_byte[6:0], 1'b0};
      if (lvl == rlegd_pkg::LEVEL_NEAR_MAX) lvl = rlegd_pkg::LEVEL_MAX;
      place_pixels(lvl, 1);
    end
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_group(rlegd_pkg::out_t got);
    rlegd_pkg::out_t want;
    logic [OW-1:0] wv;
    logic [OW-1:0] gv;
    bit bad;
    groups_seen++;
    if (pixel_groups_exp.size() == 0) begin
      note_error($sformatf("unexpected result px %h cnt %0d done %0b st %0d",
                           got[OW-1 -: 64], got.pixel_count, got.row_done, got.row_status));
      return;
    end
    want = pixel_groups_exp.pop_front();
    wv   = want;
    gv   = got;
    bad  = 1'b0;
    for (int j = 0; j < PIX_PER; j++)
      if (gv[OW-1-8*j -: 8] !== wv[OW-1-8*j -: 8]) bad = 1'b1;
    if (got.pixel_count !== want.pixel_count) bad = 1'b1;
    if (got.row_done !== want.row_done) bad = 1'b1;
    if (got.row_status !== want.row_status) bad = 1'b1;
    if (bad)
      note_error($sformatf({"result %0d: want px %h cnt %0d done %0b st %0d, ",
                            "got px %h cnt %0d done %0b st %0d"}, groups_seen,
                           wv[OW-1 -: 64], want.pixel_count, want.row_done, want.row_status,
                           gv[OW-1 -: 64], got.pixel_count, got.row_done, got.row_status));
  endfunction

  // monitor: config shadow, input transfers into the predictor, output checks
  always @(posedge clk) begin
    if (rst) begin
      width_cfg = int'(rlegd_pkg::ROW_WIDTH_RST);
      clear_row();
    end else begin
      if (cfg_we) width_cfg = int'(cfg_wdata);
      if (out_valid && out_ready) check_group(out_data);
      if (in_valid && in_ready) begin
        decode_item(in_data);
        accept_cnt++;
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && accept_cnt != issue_cnt) begin
      // transfer still pending: hold
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (code_items_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_gap = $urandom_range(1, 5) - 1;
      in_valid <= 1'b0;
    end else begin
      in_data  <= code_items_q.pop_front();
      in_valid <= 1'b1;
      issue_cnt++;
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_idle_pct) begin
      out_gap = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(logic act, logic [7:0] b);
    code_items_q.push_back(rlegd_pkg::in_t'{action: act, code_byte: b});
    items_queued++;
  endtask

  // mostly well-formed rows; now and then a header cut off by the end of row
  task automatic gen_row(bit close);
    int unsigned n;
    int unsigned len;
    bit cut;
    n   = $urandom_range(0, 6);
    cut = 1'b0;
    for (int k = 0; k < n && !cut; k++) begin
      if ($urandom_range(0, 9) < 6) begin
        push_item(rlegd_pkg::ACT_BYTE, 8'($urandom_range(0, 127)));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 15);
        push_item(rlegd_pkg::ACT_BYTE, rlegd_pkg::RUN_FLAG_MASK | 8'(len));
        if ($urandom_range(0, 19) == 0) cut = 1'b1;
        else push_item(rlegd_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
      end
    end
    if (close || cut) push_item(rlegd_pkg::ACT_END_ROW, 8'($urandom_range(0, 255)));
  endtask

  // wait until every queued item went in and every expected result came out
  task automatic drain();
    while (code_items_q.size() != 0 || issue_cnt != accept_cnt || in_valid ||
           pixel_groups_exp.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_width(logic [rlegd_pkg::ROW_WIDTH_W-1:0] w);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int unsigned widths[$];
    int unsigned target;
    widths = '{1, 256, 0, 511, 300, 7, 8, 9, 0, 0, 16};
    widths[8] = $urandom_range(1, 256);
    widths[9] = $urandom_range(1, 256);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows at the reset width
    push_item(rlegd_pkg::ACT_BYTE, 8'h00);
    push_item(rlegd_pkg::ACT_BYTE, 8'h7f);          // doubles to 254, lifted to 255
    push_item(rlegd_pkg::ACT_BYTE, 8'h7e);
    push_item(rlegd_pkg::ACT_BYTE, 8'h55);
    push_item(rlegd_pkg::ACT_BYTE, 8'h80);          // shortest run
    push_item(rlegd_pkg::ACT_BYTE, 8'h00);
    push_item(rlegd_pkg::ACT_BYTE, 8'h87);
    push_item(rlegd_pkg::ACT_BYTE, 8'hff);
    push_item(rlegd_pkg::ACT_END_ROW, 8'hff);       // pads the rest
    push_item(rlegd_pkg::ACT_END_ROW, 8'h00);       // empty row: all padding
    push_item(rlegd_pkg::ACT_BYTE, 8'hff);          // longest run overflows
    push_item(rlegd_pkg::ACT_BYTE, 8'ha5);
    push_item(rlegd_pkg::ACT_BYTE, 8'h01);          // dropped entirely
    push_item(rlegd_pkg::ACT_END_ROW, 8'h5a);       // nothing to pad, overflow status
    push_item(rlegd_pkg::ACT_BYTE, 8'h83);
    push_item(rlegd_pkg::ACT_END_ROW, 8'h00);       // header without its value
    push_item(rlegd_pkg::ACT_BYTE, 8'hff);
    push_item(rlegd_pkg::ACT_BYTE, 8'h5a);
    push_item(rlegd_pkg::ACT_BYTE, 8'h80);
    push_item(rlegd_pkg::ACT_END_ROW, 8'h00);       // truncated beats overflow
    push_item(rlegd_pkg::ACT_BYTE, 8'h8f);          // exactly fills the row
    push_item(rlegd_pkg::ACT_BYTE, 8'h11);
    push_item(rlegd_pkg::ACT_END_ROW, 8'h00);

    in_idle_pct  = 20;
    out_idle_pct = 20;

    // random phases; rows may stay open across a width change
    foreach (widths[p]) begin
      drain();
      write_width(widths[p][rlegd_pkg::ROW_WIDTH_W-1:0]);
      calm         = (p == widths.size() - 1);
      in_idle_pct  = (p % 3 == 0) ? 0 : 10 * (p % 4 + 1);
      out_idle_pct = (p % 3 == 1) ? 0 : 10 * ((p + 1) % 4 + 1);
      target = items_queued + 40;
      while (items_queued < target) gen_row(1'b1);
      if ($urandom_range(0, 1) == 0) gen_row(1'b0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (pixel_groups_exp.size() != 0)
      note_error($sformatf("%0d expected results never arrived", pixel_groups_exp.size()));

    $display("Run covered %0d input transfers and %0d result transfers over %0d rows,",
             accept_cnt, groups_seen, rows_closed);
    $display("row widths 0 to 511 with runs, literals, padding, overflow and cut headers.");
    if (errors == 0) begin
      $display("rle_glyph_row_decoder_core verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("rle_glyph_row_decoder_core verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout: %0d results still expected", pixel_groups_exp.size());
    $display("rle_glyph_row_decoder_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
